>>> hw/rtl/http3fp_pkg.sv
// Shared types, constants and helpers for the HTTP/3 frame header parser.
// No dependencies; every other file refers to it by scoped names.
package http3fp_pkg;

  localparam int ValueBits = 62;
  localparam int VarLenBits = 3;
  localparam logic [ValueBits-1:0] MaxBodyReset = ValueBits'(64'd16777216);

  localparam logic [ValueBits-1:0] TypeRsvdA = ValueBits'(8'h02);
  localparam logic [ValueBits-1:0] TypeRsvdB = ValueBits'(8'h06);
  localparam logic [ValueBits-1:0] TypeRsvdC = ValueBits'(8'h08);
  localparam logic [ValueBits-1:0] TypeRsvdD = ValueBits'(8'h09);

  typedef enum logic [1:0] {
    PhType = 2'd0,
    PhLen  = 2'd1,
    PhBody = 2'd2,
    PhHalt = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RoleType = 2'd0,
    RoleLen  = 2'd1,
    RoleBody = 2'd2,
    RoleDrop = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrReserved = 2'd1,
    ErrTooLarge = 2'd2,
    ErrHalted   = 2'd3
  } err_e;

  typedef struct packed {
    logic                 done;
    logic [ValueBits-1:0] value;
  } varint_t;

  function automatic logic is_reserved(logic [ValueBits-1:0] t);
    logic hit;
    hit = (t == TypeRsvdA) || (t == TypeRsvdB) || (t == TypeRsvdC) || (t == TypeRsvdD);
    return hit;
  endfunction

endpackage

>>> hw/rtl/http3fp_if.sv
// Valid/ready channels for the HTTP/3 frame header parser.
// Depends on http3fp_pkg for field widths.
interface http3fp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface http3fp_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          byte_role;
  logic [http3fp_pkg::ValueBits-1:0]   frame_type;
  logic [http3fp_pkg::ValueBits-1:0]   body_length;
  logic                                header_done;
  logic                                frame_end;
  logic [1:0]                          error_code;

  modport source (output valid, output byte_role, output frame_type, output body_length,
                  output header_done, output frame_end, output error_code, input ready);
  modport sink (input valid, input byte_role, input frame_type, input body_length,
                input header_done, input frame_end, input error_code, output ready);
endinterface

>>> hw/rtl/http3fp_varint.sv
// QUIC variable-length integer accumulator, one byte per request.
// Depends on http3fp_pkg.
module http3fp_varint (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  output http3fp_pkg::varint_t res_o
);

  logic [http3fp_pkg::VarLenBits-1:0] left_q, left_d;
  logic [http3fp_pkg::ValueBits-1:0]  acc_q, acc_n;

  always_comb begin
    if (left_q == '0) begin
      acc_n = http3fp_pkg::ValueBits'(byte_i[5:0]);
      case (byte_i[7:6])
        2'b00:   left_d = http3fp_pkg::VarLenBits'(0);
        2'b01:   left_d = http3fp_pkg::VarLenBits'(1);
        2'b10:   left_d = http3fp_pkg::VarLenBits'(3);
        default: left_d = http3fp_pkg::VarLenBits'(7);
      endcase
    end else begin
      acc_n  = {acc_q[http3fp_pkg::ValueBits-9:0], byte_i};
      left_d = left_q - http3fp_pkg::VarLenBits'(1);
    end
    res_o.done  = (left_d == '0);
    res_o.value = acc_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      acc_q  <= '0;
    end else if (take_i) begin
      left_q <= left_d;
      acc_q  <= res_o.done ? '0 : acc_n;
    end
  end

endmodule

>>> hw/rtl/http3_frame_header_parser.sv
// HTTP/3 frame header parser, top level.
// Depends on http3fp_pkg, http3fp_if and http3fp_varint.
//
// in_i carries one stream byte per request; res_o returns exactly one result
// per byte, in order, giving its role and, once known, the frame type and body
// length, plus header-done, frame-end and error flags. cfg_we_i/cfg_wdata_i
// write the body length cap (reset value 16777216); write it only while idle.
//
// A byte's result is registered and shows from the cycle after the byte is
// taken. Throughput is one byte per cycle while results are drained, set by
// the single result register that the parse state and the length compare feed.
// in_i.ready is high whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and back-pressures
// the byte stream without losing anything.
// Reset clears the parse state and the result valid flag and restores the cap.
// A reserved type or an over-cap length halts the parser: every later byte
// returns a drop result until the next reset.
module http3_frame_header_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  http3fp_byte_if.sink                        in_i,
  http3fp_result_if.source                    res_o,
  input  logic                                cfg_we_i,
  input  logic [http3fp_pkg::ValueBits-1:0]   cfg_wdata_i
);

  localparam int VB = http3fp_pkg::ValueBits;

  http3fp_pkg::phase_e  phase_q, phase_d;
  http3fp_pkg::varint_t vi;
  http3fp_pkg::role_e   role_d, role_q;
  http3fp_pkg::err_e    err_d, err_q;

  logic [VB-1:0] max_len_q;
  logic [VB-1:0] held_type_q, held_len_q, body_left_q;
  logic [VB-1:0] body_dec;
  logic [VB-1:0] ftype_d, ftype_q, blen_d, blen_q;
  logic          hdone_d, hdone_q, fend_d, fend_q;
  logic          vld_q;
  logic          accept, take, too_large, rsvd;

  assign in_i.ready = !vld_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign take       = accept && ((phase_q == http3fp_pkg::PhType) ||
                                 (phase_q == http3fp_pkg::PhLen));

  http3fp_varint u_varint (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.data_byte),
    .res_o  (vi)
  );

  assign too_large = (vi.value > max_len_q);
  assign rsvd      = http3fp_pkg::is_reserved(vi.value);
  assign body_dec  = (body_left_q != '0) ? body_left_q - VB'(1) : '0;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      http3fp_pkg::PhType: begin
        if (vi.done) phase_d = rsvd ? http3fp_pkg::PhHalt : http3fp_pkg::PhLen;
      end
      http3fp_pkg::PhLen: begin
        if (vi.done) begin
          if (too_large) phase_d = http3fp_pkg::PhHalt;
          else if (vi.value == '0) phase_d = http3fp_pkg::PhType;
          else phase_d = http3fp_pkg::PhBody;
        end
      end
      http3fp_pkg::PhBody: begin
        if (body_dec == '0) phase_d = http3fp_pkg::PhType;
      end
      default: phase_d = http3fp_pkg::PhHalt;
    endcase
  end

  always_comb begin
    role_d  = http3fp_pkg::RoleDrop;
    err_d   = http3fp_pkg::ErrHalted;
    ftype_d = '0;
    blen_d  = '0;
    hdone_d = 1'b0;
    fend_d  = 1'b0;
    case (phase_q)
      http3fp_pkg::PhType: begin
        role_d = http3fp_pkg::RoleType;
        err_d  = http3fp_pkg::ErrNone;
        if (vi.done) begin
          ftype_d = vi.value;
          if (rsvd) err_d = http3fp_pkg::ErrReserved;
        end
      end
      http3fp_pkg::PhLen: begin
        role_d  = http3fp_pkg::RoleLen;
        err_d   = http3fp_pkg::ErrNone;
        ftype_d = held_type_q;
        if (vi.done) begin
          blen_d = vi.value;
          if (too_large) begin
            err_d = http3fp_pkg::ErrTooLarge;
          end else begin
            hdone_d = 1'b1;
            fend_d  = (vi.value == '0);
          end
        end
      end
      http3fp_pkg::PhBody: begin
        role_d  = http3fp_pkg::RoleBody;
        err_d   = http3fp_pkg::ErrNone;
        ftype_d = held_type_q;
        blen_d  = held_len_q;
        fend_d  = (body_dec == '0);
      end
      default: begin
        role_d = http3fp_pkg::RoleDrop;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= http3fp_pkg::PhType;
      max_len_q   <= http3fp_pkg::MaxBodyReset;
      body_left_q <= '0;
      vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (accept) begin
        phase_q <= phase_d;
        if (phase_q == http3fp_pkg::PhLen) body_left_q <= vi.value;
        else if (phase_q == http3fp_pkg::PhBody) body_left_q <= body_dec;
      end
      if (accept) vld_q <= 1'b1;
      else if (res_o.ready) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (phase_q == http3fp_pkg::PhType && vi.done) held_type_q <= vi.value;
      if (phase_q == http3fp_pkg::PhLen && vi.done) held_len_q <= vi.value;
      role_q  <= role_d;
      err_q   <= err_d;
      ftype_q <= ftype_d;
      blen_q  <= blen_d;
      hdone_q <= hdone_d;
      fend_q  <= fend_d;
    end
  end

  assign res_o.valid       = vld_q;
  assign res_o.byte_role   = role_q;
  assign res_o.error_code  = err_q;
  assign res_o.frame_type  = ftype_q;
  assign res_o.body_length = blen_q;
  assign res_o.header_done = hdone_q;
  assign res_o.frame_end   = fend_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == http3fp_pkg::PhHalt |=> phase_q == http3fp_pkg::PhHalt)
    else $error("parser left halt state");

  a_hdone_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.header_done |->
      res_o.error_code == http3fp_pkg::ErrNone && res_o.byte_role == http3fp_pkg::RoleLen)
    else $error("header done on a bad or non-length byte");

  a_fend_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_end |->
      res_o.byte_role == http3fp_pkg::RoleLen || res_o.byte_role == http3fp_pkg::RoleBody)
    else $error("frame end on a type or dropped byte");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !res_o.ready |-> !in_i.ready)
    else $error("request taken while result stalled");

endmodule
